>>> rtl/core/shift_register_chain_driver_unit_assert.svh
// Assertion helpers used by the checker file.
`ifndef SHIFT_REGISTER_CHAIN_DRIVER_UNIT_ASSERT_SVH
`define SHIFT_REGISTER_CHAIN_DRIVER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/srcd_pkg.sv
`timescale 1ns / 1ps

package srcd_pkg;

  // Largest number of chained 8-bit registers supported.
  localparam int unsigned MAX_OCTETS = 4;
  localparam int unsigned OCTET_W    = 8;
  localparam int unsigned SHIFT_W    = MAX_OCTETS * OCTET_W;
  localparam int unsigned CNT_W      = $clog2(SHIFT_W + 1);
  localparam int unsigned BIT_IDX_W  = $clog2(SHIFT_W);

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned SIZE_W     = 3;
  localparam int unsigned TYPE_W     = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_TYPE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_OCTETS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd4;

  // Job kinds; the first three match the register type codes.
  localparam logic [TYPE_W-1:0] JOB_READ   = 2'd0;
  localparam logic [TYPE_W-1:0] JOB_WRITE  = 2'd1;
  localparam logic [TYPE_W-1:0] JOB_HYBRID = 2'd2;
  localparam logic [TYPE_W-1:0] JOB_FILL   = 2'd3;

  // Register values after reset.
  localparam logic [TYPE_W-1:0]  RST_REG_TYPE    = JOB_WRITE;
  localparam logic [SIZE_W-1:0]  RST_SIZE_OCTETS = 3'd4;
  localparam logic [DELAY_W-1:0] RST_CLOCK_DELAY = 16'd5;
  localparam logic [DELAY_W-1:0] RST_LATCH_DELAY = 16'd5;

  // Number of bits in the chain, with the size clamped to 1..MAX_OCTETS.
  function automatic logic [CNT_W-1:0] chain_bits(input logic [SIZE_W-1:0] size);
    logic [CNT_W-1:0] n;
    if (size == '0) begin
      n = CNT_W'(1);
    end else if (32'(size) > MAX_OCTETS) begin
      n = CNT_W'(MAX_OCTETS);
    end else begin
      n = CNT_W'(size);
    end
    return CNT_W'(n * CNT_W'(OCTET_W));
  endfunction

  // Reload value of the tick counter: a zero delay still lasts one tick.
  function automatic logic [DELAY_W-1:0] ticks_minus_one(input logic [DELAY_W-1:0] d);
    return (d == '0) ? '0 : d - DELAY_W'(1);
  endfunction

endpackage

>>> rtl/core/srcd_ifs.sv
`timescale 1ns / 1ps

// Tick channel: one request per timing tick.
interface srcd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         start_update;
  logic                         start_fill;
  logic                         fill_value;
  logic [srcd_pkg::WORD_W-1:0]  out_word;
  logic                         serial_in;

  modport source (output valid, start_update, start_fill, fill_value, out_word, serial_in,
                  input ready);
  modport sink   (input valid, start_update, start_fill, fill_value, out_word, serial_in,
                  output ready);
endinterface

// Pin and status channel: one request per tick.
interface srcd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         shift_clock;
  logic                         serial_out;
  logic                         latch_pin;
  logic                         busy_res;
  logic                         done_res;
  logic [srcd_pkg::WORD_W-1:0]  in_word;

  modport source (output valid, shift_clock, serial_out, latch_pin, busy_res, done_res,
                  in_word, input ready);
  modport sink   (input valid, shift_clock, serial_out, latch_pin, busy_res, done_res,
                  in_word, output ready);
endinterface

// Register write channel.
interface srcd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [srcd_pkg::CFG_IDX_W-1:0]    index;
  logic [srcd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/shift_register_chain_driver_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Carries
// in_ch     sink       one timing tick: start requests, fill bit, word, serial_in level
// out_ch    source     pin levels, busy and done flags, last word read
// cfg_ch    sink       register index and write data
//
// Every request on in_ch is one tick and produces exactly one request on out_ch.
// The block takes one tick per clock cycle unless out_ch stalls; the job state and
// pin levels are updated when a tick is accepted and are shown on out_ch the next cycle.
// rst_n is synchronous and active low; it idles the job and loads register defaults.
// out_ch is a single output register: a tick is accepted whenever that register is
// empty or is being taken in the same cycle, so a stall on out_ch stalls in_ch.
// Register writes are always accepted (cfg_ch.ready is tied high).

module shift_register_chain_driver_unit (
  input  logic         clk,
  input  logic         rst_n,
  srcd_in_if.sink      in_ch,
  srcd_out_if.source   out_ch,
  srcd_cfg_if.sink     cfg_ch
);

  // Job phases.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_W_HI  = 4'd1;
  localparam logic [3:0] PH_W_LO  = 4'd2;
  localparam logic [3:0] PH_LATCH = 4'd3;
  localparam logic [3:0] PH_R_HI  = 4'd4;
  localparam logic [3:0] PH_R_LO  = 4'd5;

  // Configuration registers.
  logic [srcd_pkg::TYPE_W-1:0]  reg_type_r;
  logic [srcd_pkg::SIZE_W-1:0]  size_octets_r;
  logic [srcd_pkg::DELAY_W-1:0] clock_delay_r;
  logic [srcd_pkg::DELAY_W-1:0] latch_delay_r;
  logic                         invert_r;

  // Job state. The pin levels are state too and drive out_ch directly.
  logic [3:0]                    phase_r,     phase_nxt;
  logic [srcd_pkg::TYPE_W-1:0]   job_r,       job_nxt;
  logic [srcd_pkg::CNT_W-1:0]    bit_cnt_r,   bit_cnt_nxt;
  logic [srcd_pkg::DELAY_W-1:0]  delay_r,     delay_nxt;
  logic [srcd_pkg::SHIFT_W-1:0]  out_shift_r, out_shift_nxt;
  logic [srcd_pkg::SHIFT_W-1:0]  in_shift_r,  in_shift_nxt;
  logic [srcd_pkg::SHIFT_W-1:0]  read_word_r, read_word_nxt;
  logic                          fill_bit_r,  fill_bit_nxt;
  logic                          pin_clk_r,   pin_clk_nxt;
  logic                          pin_data_r,  pin_data_nxt;
  logic                          pin_latch_r, pin_latch_nxt;
  logic                          done_r,      done_nxt;
  logic                          out_valid_r;

  logic                              accept;
  logic                              upd_req;
  logic                              go_write_high;
  logic                              go_read_high;
  logic                              go_low;
  logic [3:0]                        low_phase;
  logic [srcd_pkg::BIT_IDX_W-1:0]    bit_idx;
  logic [srcd_pkg::CNT_W-1:0]        chain_len;
  logic [srcd_pkg::DELAY_W-1:0]      clock_reload;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign chain_len    = srcd_pkg::chain_bits(size_octets_r);
  assign clock_reload = srcd_pkg::ticks_minus_one(clock_delay_r);

  // Register writes must arrive only while the job is idle; the block does not check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_type_r    <= srcd_pkg::RST_REG_TYPE;
      size_octets_r <= srcd_pkg::RST_SIZE_OCTETS;
      clock_delay_r <= srcd_pkg::RST_CLOCK_DELAY;
      latch_delay_r <= srcd_pkg::RST_LATCH_DELAY;
      invert_r      <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        srcd_pkg::REG_TYPE:        reg_type_r    <= cfg_ch.data[srcd_pkg::TYPE_W-1:0];
        srcd_pkg::REG_SIZE_OCTETS: size_octets_r <= cfg_ch.data[srcd_pkg::SIZE_W-1:0];
        srcd_pkg::REG_CLOCK_DELAY: clock_delay_r <= cfg_ch.data[srcd_pkg::DELAY_W-1:0];
        srcd_pkg::REG_LATCH_DELAY: latch_delay_r <= cfg_ch.data[srcd_pkg::DELAY_W-1:0];
        srcd_pkg::REG_INVERT:      invert_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // One tick of the job sequencer. The case below decides which phase is
  // entered next; entering a clock phase is applied afterwards so that a new
  // job and a running one share the same pin logic.
  always_comb begin
    phase_nxt     = phase_r;
    job_nxt       = job_r;
    bit_cnt_nxt   = bit_cnt_r;
    delay_nxt     = delay_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    read_word_nxt = read_word_r;
    fill_bit_nxt  = fill_bit_r;
    pin_clk_nxt   = pin_clk_r;
    pin_data_nxt  = pin_data_r;
    pin_latch_nxt = pin_latch_r;
    done_nxt      = 1'b0;
    go_write_high = 1'b0;
    go_read_high  = 1'b0;
    go_low        = 1'b0;
    low_phase     = PH_W_LO;
    // An update request with the unused type code counts as absent.
    upd_req       = in_ch.start_update && (reg_type_r != srcd_pkg::JOB_FILL);

    if (phase_r == PH_IDLE) begin
      if (upd_req || in_ch.start_fill) begin
        job_nxt       = upd_req ? reg_type_r : srcd_pkg::JOB_FILL;
        fill_bit_nxt  = in_ch.fill_value;
        out_shift_nxt = srcd_pkg::SHIFT_W'(in_ch.out_word);
        bit_cnt_nxt   = chain_len;
        if (job_nxt == srcd_pkg::JOB_READ) begin
          in_shift_nxt = '0;
          go_read_high = 1'b1;
        end else begin
          go_write_high = 1'b1;
        end
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - srcd_pkg::DELAY_W'(1);
    end else begin
      unique case (phase_r)
        PH_W_HI: begin
          go_low    = 1'b1;
          low_phase = PH_W_LO;
        end
        PH_W_LO: begin
          if (bit_cnt_r != '0) begin
            bit_cnt_nxt = bit_cnt_r - srcd_pkg::CNT_W'(1);
          end
          if (bit_cnt_nxt != '0) begin
            go_write_high = 1'b1;
          end else if (job_r == srcd_pkg::JOB_HYBRID) begin
            // Write half done: reload the count and read the chain back.
            bit_cnt_nxt  = chain_len;
            in_shift_nxt = '0;
            go_read_high = 1'b1;
          end else begin
            pin_latch_nxt = 1'b1;
            phase_nxt     = PH_LATCH;
            delay_nxt     = srcd_pkg::ticks_minus_one(latch_delay_r);
          end
        end
        PH_R_HI: begin
          go_low    = 1'b1;
          low_phase = PH_R_LO;
        end
        PH_R_LO: begin
          if (bit_cnt_r != '0) begin
            bit_cnt_nxt = bit_cnt_r - srcd_pkg::CNT_W'(1);
          end
          if (bit_cnt_nxt != '0) begin
            go_read_high = 1'b1;
          end else begin
            read_word_nxt = in_shift_r;
            phase_nxt     = PH_IDLE;
            done_nxt      = 1'b1;
          end
        end
        default: begin
          // Latch pulse over, or an unknown phase: return to idle.
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      endcase
      if (done_nxt) begin
        pin_clk_nxt   = 1'b0;
        pin_latch_nxt = 1'b0;
        bit_cnt_nxt   = '0;
        delay_nxt     = '0;
      end
    end

    // The data bit for a write comes from the remaining count, MSB first.
    bit_idx = srcd_pkg::BIT_IDX_W'(bit_cnt_nxt - srcd_pkg::CNT_W'(1));

    if (go_write_high) begin
      if (job_nxt == srcd_pkg::JOB_FILL) begin
        pin_data_nxt = fill_bit_nxt;
      end else begin
        pin_data_nxt = out_shift_nxt[bit_idx] ^ invert_r;
      end
      pin_clk_nxt = 1'b1;
      phase_nxt   = PH_W_HI;
      delay_nxt   = clock_reload;
    end
    if (go_read_high) begin
      // serial_in is sampled as the clock rises.
      in_shift_nxt  = {in_shift_nxt[srcd_pkg::SHIFT_W-2:0], in_ch.serial_in};
      pin_clk_nxt   = 1'b1;
      pin_latch_nxt = 1'b1;
      phase_nxt     = PH_R_HI;
      delay_nxt     = clock_reload;
    end
    if (go_low) begin
      pin_clk_nxt = 1'b0;
      phase_nxt   = low_phase;
      delay_nxt   = clock_reload;
    end
  end

  // State advances only on an accepted tick, so while out_ch stalls the pin
  // levels and flags it shows stay put.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      job_r       <= srcd_pkg::JOB_READ;
      bit_cnt_r   <= '0;
      delay_r     <= '0;
      out_shift_r <= '0;
      in_shift_r  <= '0;
      read_word_r <= '0;
      fill_bit_r  <= 1'b0;
      pin_clk_r   <= 1'b0;
      pin_data_r  <= 1'b0;
      pin_latch_r <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        job_r       <= job_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        delay_r     <= delay_nxt;
        out_shift_r <= out_shift_nxt;
        in_shift_r  <= in_shift_nxt;
        read_word_r <= read_word_nxt;
        fill_bit_r  <= fill_bit_nxt;
        pin_clk_r   <= pin_clk_nxt;
        pin_data_r  <= pin_data_nxt;
        pin_latch_r <= pin_latch_nxt;
        done_r      <= done_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.shift_clock = pin_clk_r;
  assign out_ch.serial_out  = pin_data_r;
  assign out_ch.latch_pin   = pin_latch_r;
  assign out_ch.busy_res    = (phase_r != PH_IDLE);
  assign out_ch.done_res    = done_r;
  assign out_ch.in_word     = srcd_pkg::WORD_W'(read_word_r);

endmodule

>>> rtl/core/srcd_checker.sv
`timescale 1ns / 1ps

`include "shift_register_chain_driver_unit_assert.svh"

module srcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        shift_clock,
  input logic                        serial_out,
  input logic                        latch_pin,
  input logic                        busy_res,
  input logic                        done_res,
  input logic [srcd_pkg::WORD_W-1:0] in_word
);

  logic                        stalled;
  logic                        tick_taken;
  logic                        at_rest;
  logic [srcd_pkg::WORD_W+4:0] shown;

  assign stalled    = out_valid && !out_ready;
  assign tick_taken = in_valid && in_ready;
  assign at_rest    = !busy_res && !shift_clock && !latch_pin;
  assign shown      = {shift_clock, serial_out, latch_pin, busy_res, done_res, in_word};

  // A stalled result keeps its contents.
  `SRCD_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(shown), "stalled result changed")

  // A completed job leaves the pins at rest and the block idle.
  `SRCD_ASSERT_NOW(a_done_idle, out_valid && done_res, at_rest, "done with job still active")

  // Every accepted tick yields a result in the next cycle.
  `SRCD_ASSERT_NEXT(a_tick_result, tick_taken, out_valid, "accepted tick gave no result")

  // No tick is taken while the held result is not being drained.
  `SRCD_ASSERT_NOW(a_no_overrun, stalled, !in_ready, "tick accepted over a stalled result")

endmodule

bind shift_register_chain_driver_unit srcd_checker u_srcd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .shift_clock (out_ch.shift_clock),
  .serial_out  (out_ch.serial_out),
  .latch_pin   (out_ch.latch_pin),
  .busy_res    (out_ch.busy_res),
  .done_res    (out_ch.done_res),
  .in_word     (out_ch.in_word)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srcd_pkg::*;

  // Ways of driving the serial data input during a job.
  localparam logic [1:0] SIN_LOW  = 2'd0;
  localparam logic [1:0] SIN_HIGH = 2'd1;
  localparam logic [1:0] SIN_RAND = 2'd2;

  // The fourth type code has no job of its own; an update request under it is dropped.
  localparam logic [TYPE_W-1:0] TYPE_UNUSED = JOB_FILL;

  localparam int RANDOM_PHASES   = 4;
  localparam int TICKS_PER_PHASE = 35;
  localparam int NUM_ROWS        = 16;

  // Phases of a job as the model in this bench tracks them.
  typedef enum logic [2:0] {
    PH_IDLE, PH_W_HI, PH_W_LO, PH_LATCH, PH_R_HI, PH_R_LO
  } chain_phase_e;

  // One timing tick as offered on the tick channel.
  typedef struct packed {
    logic              start_update;
    logic              start_fill;
    logic              fill_value;
    logic [WORD_W-1:0] out_word;
    logic              serial_in;
  } tick_t;

  // Pin levels and status reported for one tick.
  typedef struct packed {
    logic              shift_clock;
    logic              serial_out;
    logic              latch_pin;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] in_word;
  } pins_t;

  // One directed job: the register settings, the starting tick, how serial_in behaves
  // while the job runs, and, where it is obvious, the word that must be read back.
  typedef struct packed {
    logic               wr_cfg;
    logic [TYPE_W-1:0]  rtype;
    logic [SIZE_W-1:0]  size;
    logic [DELAY_W-1:0] clk_dly;
    logic [DELAY_W-1:0] latch_dly;
    logic               inv;
    logic               upd;
    logic               fill;
    logic               fval;
    logic [WORD_W-1:0]  word;
    logic [1:0]         sin_mode;
    logic               poke;      // raise start requests at random while busy
    logic               quiet;     // no idling on either side for this job
    logic               chk;
    logic [WORD_W-1:0]  exp_word;
  } job_row_t;

  logic clk;
  logic rst_n;

  srcd_in_if  in_if ();
  srcd_out_if out_if ();
  srcd_cfg_if cfg_if ();

  shift_register_chain_driver_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // The directed jobs. Rows that only make sense against the model leave chk low.
  job_row_t jobs [NUM_ROWS] = '{
    // Right after reset: an idle tick shows all pins low and a zero word.
    '{1'b0, JOB_READ, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000,
      SIN_LOW, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
    // Reads of one octet, a constant low input and a random one.
    '{1'b1, JOB_READ, 3'd1, 16'd1, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000,
      SIN_LOW, 1'b1, 1'b0, 1'b1, 32'h0000_0000},
    '{1'b1, JOB_READ, 3'd1, 16'd0, 16'd2, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000,
      SIN_RAND, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    // Hybrid with inversion on the written half.
    '{1'b1, JOB_HYBRID, 3'd1, 16'd1, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 32'h8000_0001,
      SIN_RAND, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    // A write of the zero word on a slower clock.
    '{1'b1, JOB_WRITE, 3'd1, 16'd2, 16'd1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000,
      SIN_RAND, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    // Fill jobs ignore the inversion bit and the configured type.
    '{1'b1, JOB_WRITE, 3'd1, 16'd0, 16'd2, 1'b1, 1'b0, 1'b1, 1'b1, 32'h5A5A_5A5A,
      SIN_RAND, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{1'b1, JOB_READ, 3'd1, 16'd1, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF,
      SIN_HIGH, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    // Both requests at once: the update wins, and the one-octet read returns all ones.
    '{1'b1, JOB_HYBRID, 3'd1, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_00C3,
      SIN_HIGH, 1'b0, 1'b0, 1'b1, 32'h0000_00FF},
    // Unused type: an update alone does nothing, with a fill request the fill runs.
    '{1'b1, TYPE_UNUSED, 3'd1, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h1234_5678,
      SIN_LOW, 1'b0, 1'b0, 1'b1, 32'h0000_00FF},
    '{1'b1, TYPE_UNUSED, 3'd1, 16'd0, 16'd1, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000,
      SIN_LOW, 1'b0, 1'b0, 1'b1, 32'h0000_00FF},
    // Size zero counts as one octet, sizes above the maximum as the maximum, which
    // gives a full-width read and a full-width inverted write of the all-ones word.
    '{1'b1, JOB_READ, 3'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000,
      SIN_HIGH, 1'b0, 1'b0, 1'b1, 32'h0000_00FF},
    '{1'b1, JOB_READ, 3'd7, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000,
      SIN_HIGH, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{1'b1, JOB_WRITE, 3'd5, 16'd0, 16'd1, 1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF,
      SIN_RAND, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    // A long latch pulse on a single octet.
    '{1'b1, JOB_WRITE, 3'd1, 16'd0, 16'd20, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_00A5,
      SIN_RAND, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
    // Longest clock delay is only loaded here; no job is started at that rate.
    '{1'b1, JOB_WRITE, 3'd4, 16'hFFFF, 16'd5, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000,
      SIN_RAND, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
    // A slower clock on a read with the longest latch delay loaded; a read has no
    // latch pulse.
    '{1'b1, JOB_READ, 3'd1, 16'd3, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000,
      SIN_RAND, 1'b1, 1'b0, 1'b0, 32'h0000_0000}
  };

  // Register copies kept by the bench.
  logic [TYPE_W-1:0]  cur_type;
  logic [SIZE_W-1:0]  cur_size;
  logic [DELAY_W-1:0] cur_clk_dly;
  logic [DELAY_W-1:0] cur_latch_dly;
  logic               cur_invert;

  // Job state of the bench's own model of the driver.
  chain_phase_e       ph;
  logic [TYPE_W-1:0]  job;
  logic [5:0]         bits_left;
  logic [DELAY_W-1:0] dly;
  logic [WORD_W-1:0]  word_sh;
  logic [WORD_W-1:0]  rd_sh;
  logic [WORD_W-1:0]  rd_word;
  logic               fill_bit;
  logic               pin_clk;
  logic               pin_data;
  logic               pin_latch;
  logic               job_done;

  // Pin levels owed by the block, oldest first, one per accepted tick.
  pins_t       due_pins [$];
  pins_t       want_pins;
  logic [WORD_W-1:0] seen_word = '0;
  int          mismatches = 0;
  bit          idle_on;
  int unsigned stall_left;

  // --------------------------------------------------------------------------
  // Model of the driver. Each accepted tick advances it by exactly one step.
  // --------------------------------------------------------------------------

  // Bits in the chain, with the size clamped to one octet up to the maximum.
  function automatic logic [5:0] chain_len();
    int unsigned n;
    n = 32'(cur_size);
    if (n == 0) n = 1;
    if (n > MAX_OCTETS) n = MAX_OCTETS;
    return 6'(n * OCTET_W);
  endfunction

  // Counter reload for a delay; a zero delay still lasts one tick.
  function automatic logic [DELAY_W-1:0] hold_ticks(input logic [DELAY_W-1:0] d);
    return (d == '0) ? '0 : d - DELAY_W'(1);
  endfunction

  // Present the next data bit and raise the clock. Fill bits are never inverted.
  function automatic void drive_write_bit();
    if (job == JOB_FILL) begin
      pin_data = fill_bit;
    end else begin
      pin_data = word_sh[BIT_IDX_W'(bits_left - 6'd1)] ^ cur_invert;
    end
    pin_clk = 1'b1;
    ph      = PH_W_HI;
    dly     = hold_ticks(cur_clk_dly);
  endfunction

  // Sample the serial input as the clock rises; the latch stays high through a read.
  function automatic void sample_bit(input logic s);
    rd_sh     = {rd_sh[WORD_W-2:0], s};
    pin_clk   = 1'b1;
    pin_latch = 1'b1;
    ph        = PH_R_HI;
    dly       = hold_ticks(cur_clk_dly);
  endfunction

  function automatic void go_low(input chain_phase_e nxt);
    pin_clk = 1'b0;
    ph      = nxt;
    dly     = hold_ticks(cur_clk_dly);
  endfunction

  function automatic void wrap_up();
    pin_clk   = 1'b0;
    pin_latch = 1'b0;
    ph        = PH_IDLE;
    bits_left = '0;
    dly       = '0;
    job_done  = 1'b1;
  endfunction

  function automatic pins_t advance_chain(input tick_t t);
    logic  upd;
    pins_t p;
    job_done = 1'b0;
    if (ph == PH_IDLE) begin
      // An update under the unused type is dropped, so a fill request can still start.
      upd = t.start_update && (cur_type <= JOB_HYBRID);
      if (upd || t.start_fill) begin
        job       = upd ? cur_type : JOB_FILL;
        fill_bit  = t.fill_value;
        word_sh   = t.out_word;
        bits_left = chain_len();
        if (job == JOB_READ) begin
          rd_sh = '0;
          sample_bit(t.serial_in);
        end else begin
          drive_write_bit();
        end
      end
    end else if (dly != '0) begin
      dly = dly - DELAY_W'(1);
    end else begin
      case (ph)
        PH_W_HI: go_low(PH_W_LO);
        PH_W_LO: begin
          if (bits_left != '0) bits_left = bits_left - 6'd1;
          if (bits_left != '0) begin
            drive_write_bit();
          end else if (job == JOB_HYBRID) begin
            // The written half is done: raise the latch and read the same length.
            bits_left = chain_len();
            rd_sh     = '0;
            sample_bit(t.serial_in);
          end else begin
            pin_latch = 1'b1;
            ph        = PH_LATCH;
            dly       = hold_ticks(cur_latch_dly);
          end
        end
        PH_LATCH: wrap_up();
        PH_R_HI: go_low(PH_R_LO);
        PH_R_LO: begin
          if (bits_left != '0) bits_left = bits_left - 6'd1;
          if (bits_left != '0) begin
            sample_bit(t.serial_in);
          end else begin
            rd_word = rd_sh;
            wrap_up();
          end
        end
        default: wrap_up();
      endcase
    end
    p.shift_clock = pin_clk;
    p.serial_out  = pin_data;
    p.latch_pin   = pin_latch;
    p.busy_res    = (ph != PH_IDLE);
    p.done_res    = job_done;
    p.in_word     = rd_word;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking.
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic compare_pins(input pins_t want);
    if (out_if.shift_clock !== want.shift_clock)
      flag_mismatch("shift_clock", WORD_W'(out_if.shift_clock), WORD_W'(want.shift_clock));
    if (out_if.serial_out !== want.serial_out)
      flag_mismatch("serial_out", WORD_W'(out_if.serial_out), WORD_W'(want.serial_out));
    if (out_if.latch_pin !== want.latch_pin)
      flag_mismatch("latch_pin", WORD_W'(out_if.latch_pin), WORD_W'(want.latch_pin));
    if (out_if.busy_res !== want.busy_res)
      flag_mismatch("busy_res", WORD_W'(out_if.busy_res), WORD_W'(want.busy_res));
    if (out_if.done_res !== want.done_res)
      flag_mismatch("done_res", WORD_W'(out_if.done_res), WORD_W'(want.done_res));
    if (out_if.in_word !== want.in_word)
      flag_mismatch("in_word", out_if.in_word, want.in_word);
  endtask

  // Every request taken on the pin channel is held against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_pins.size() == 0) begin
        flag_mismatch("request with nothing owed", out_if.in_word, '0);
      end else begin
        want_pins = due_pins.pop_front();
        compare_pins(want_pins);
      end
      seen_word = out_if.in_word;
    end
  end

  // --------------------------------------------------------------------------
  // Clock, timeout and the pin channel's back-pressure.
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far above the longest run, even with every gap and stall taken.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver stalls at random while idling is enabled.
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Everything below runs from one process and leaves each task on a
  // falling edge, so inputs only ever change there.
  // --------------------------------------------------------------------------

  // Offer one tick, with an occasional gap first, and book its expected pins once
  // the request is taken.
  task automatic send_tick(input tick_t t);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.start_update <= t.start_update;
    in_if.start_fill   <= t.start_fill;
    in_if.fill_value   <= t.fill_value;
    in_if.out_word     <= t.out_word;
    in_if.serial_in    <= t.serial_in;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    due_pins.push_back(advance_chain(t));
    @(negedge clk);
  endtask

  function automatic logic pick_serial(input logic [1:0] mode);
    case (mode)
      SIN_LOW:  return 1'b0;
      SIN_HIGH: return 1'b1;
      default:  return 1'($urandom);
    endcase
  endfunction

  // Keep ticking until the job in progress has finished. With poke set, start requests
  // arrive while busy and must be ignored.
  task automatic run_out_job(input logic poke, input logic [1:0] sin_mode);
    tick_t t;
    while (ph != PH_IDLE) begin
      t.start_update = poke && ($urandom_range(0, 3) == 0);
      t.start_fill   = poke && ($urandom_range(0, 3) == 0);
      t.fill_value   = 1'($urandom);
      t.out_word     = $urandom;
      t.serial_in    = pick_serial(sin_mode);
      send_tick(t);
    end
  endtask

  // Stop offering ticks and wait until every owed request has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (due_pins.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // One register write; the bench's copy changes in the cycle the write is taken.
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_TYPE:        cur_type      = data[TYPE_W-1:0];
      REG_SIZE_OCTETS: cur_size      = data[SIZE_W-1:0];
      REG_CLOCK_DELAY: cur_clk_dly   = data[DELAY_W-1:0];
      REG_LATCH_DELAY: cur_latch_dly = data[DELAY_W-1:0];
      REG_INVERT:      cur_invert    = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Load all five registers, then poke an index past the last one, which must be ignored.
  task automatic program_regs(input logic [TYPE_W-1:0] rtype, input logic [SIZE_W-1:0] size,
                              input logic [DELAY_W-1:0] clk_dly,
                              input logic [DELAY_W-1:0] latch_dly, input logic inv);
    cfg_put(REG_TYPE, CFG_DATA_W'(rtype));
    cfg_put(REG_SIZE_OCTETS, CFG_DATA_W'(size));
    cfg_put(REG_CLOCK_DELAY, CFG_DATA_W'(clk_dly));
    cfg_put(REG_LATCH_DELAY, CFG_DATA_W'(latch_dly));
    cfg_put(REG_INVERT, CFG_DATA_W'(inv));
    cfg_put(CFG_IDX_W'($urandom_range(REG_INVERT + 1, (1 << CFG_IDX_W) - 1)),
            CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    tick_t t;
    int    pick;

    // Every input known from time zero.
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.start_update = 1'b0;
    in_if.start_fill   = 1'b0;
    in_if.fill_value   = 1'b0;
    in_if.out_word     = '0;
    in_if.serial_in    = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    idle_on            = 1'b1;

    // Register values and job state after reset.
    cur_type      = RST_REG_TYPE;
    cur_size      = RST_SIZE_OCTETS;
    cur_clk_dly   = RST_CLOCK_DELAY;
    cur_latch_dly = RST_LATCH_DELAY;
    cur_invert    = 1'b0;
    ph            = PH_IDLE;
    job           = JOB_READ;
    bits_left     = '0;
    dly           = '0;
    word_sh       = '0;
    rd_sh         = '0;
    rd_word       = '0;
    fill_bit      = 1'b0;
    pin_clk       = 1'b0;
    pin_data      = 1'b0;
    pin_latch     = 1'b0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed jobs: configure while idle, start the job, run it out, then check the
    // word read back where the row gives one.
    for (int i = 0; i < NUM_ROWS; i++) begin
      idle_on = !jobs[i].quiet;
      if (jobs[i].wr_cfg) begin
        program_regs(jobs[i].rtype, jobs[i].size, jobs[i].clk_dly, jobs[i].latch_dly,
                     jobs[i].inv);
      end
      t.start_update = jobs[i].upd;
      t.start_fill   = jobs[i].fill;
      t.fill_value   = jobs[i].fval;
      t.out_word     = jobs[i].word;
      t.serial_in    = pick_serial(jobs[i].sin_mode);
      send_tick(t);
      run_out_job(jobs[i].poke, jobs[i].sin_mode);
      settle();
      if (jobs[i].chk && seen_word !== jobs[i].exp_word) begin
        flag_mismatch("in_word after directed job", seen_word, jobs[i].exp_word);
      end
    end

    // Random phases. Each picks a setting with short delays and mostly small chains,
    // then runs random ticks: new jobs start often, and starts while busy are thrown in.
    // The last phase runs without idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      program_regs(($urandom_range(0, 7) == 0) ? TYPE_UNUSED
                                               : TYPE_W'($urandom_range(0, 2)),
                   ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 7))
                                               : SIZE_W'($urandom_range(1, 2)),
                   DELAY_W'($urandom_range(0, 2)), DELAY_W'($urandom_range(0, 4)),
                   1'($urandom));
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        if (ph == PH_IDLE) begin
          pick           = $urandom_range(0, 3);
          t.start_update = (pick == 1) || (pick == 3);
          t.start_fill   = (pick == 2) || (pick == 3);
        end else begin
          t.start_update = ($urandom_range(0, 3) == 0);
          t.start_fill   = ($urandom_range(0, 3) == 0);
        end
        t.fill_value = 1'($urandom);
        t.out_word   = $urandom;
        t.serial_in  = 1'($urandom);
        send_tick(t);
      end
      run_out_job(1'($urandom), SIN_RAND);
      settle();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/srcd_pkg.sv
rtl/core/srcd_ifs.sv
rtl/core/shift_register_chain_driver_unit.sv
rtl/core/srcd_checker.sv
sim/tb_top.sv
